FILE: rtl/mcod_pkg.sv
// ----------------------------------------------------------------------------
// mcod_pkg
// Shared types and constants of the matrix chain order core.
// ----------------------------------------------------------------------------
package mcod_pkg;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int DIM_FIELD_W = 12;
    localparam int IDX_W       = 4;
    localparam int COST_W      = 40;
    localparam int SPLIT_W     = 4;
    localparam int STATUS_W    = 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_CHAIN  = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_TOO_MANY  = 2'd3
    } status_t;

    typedef struct packed {
        logic clr;
        logic cap_a;
        logic mul_ab;
        logic mul_k;
        logic sum;
        logic cmp;
    } alu_ctl_t;

endpackage

FILE: rtl/mcod_ram_1r.sv
// ----------------------------------------------------------------------------
// mcod_ram_1r
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module mcod_ram_1r #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mcod_ram_2r.sv
// ----------------------------------------------------------------------------
// mcod_ram_2r
// Single write port, dual registered read port memory.
// ----------------------------------------------------------------------------
module mcod_ram_2r #(
    parameter int WIDTH = 40,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/mcod_alu.sv
// ----------------------------------------------------------------------------
// mcod_alu
// Shared cost unit: dimension products, saturating cost sum, running minimum.
// ----------------------------------------------------------------------------
module mcod_alu #(
    parameter int DIM_BITS = 12,
    parameter int IW       = 4
) (
    input  logic                          aclk,
    input  mcod_pkg::alu_ctl_t            ctl,
    input  logic [DIM_BITS-1:0]           dim_rdata,
    input  logic [mcod_pkg::COST_W-1:0]   cost_l,
    input  logic [mcod_pkg::COST_W-1:0]   cost_r,
    input  logic [IW-1:0]                 split_cand,
    output logic [mcod_pkg::COST_W-1:0]   best_cost,
    output logic [IW-1:0]                 best_split
);

    localparam int P1W = 2 * DIM_BITS;
    localparam int PW  = 3 * DIM_BITS;
    localparam int SW  = ((PW > mcod_pkg::COST_W) ? PW : mcod_pkg::COST_W) + 2;

    logic [DIM_BITS-1:0]         da_reg;
    logic [P1W-1:0]              p1_reg;
    logic [PW-1:0]               prod_reg;
    logic [mcod_pkg::COST_W-1:0] q_reg;
    logic [mcod_pkg::COST_W-1:0] best_reg;
    logic [IW-1:0]               best_k_reg;
    logic                        have_reg;
    logic [SW-1:0]               sum;

    assign sum = SW'(cost_l) + SW'(cost_r) + SW'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctl.cap_a) begin
            da_reg <= dim_rdata;
        end
        if (ctl.mul_ab) begin
            p1_reg <= P1W'(da_reg) * P1W'(dim_rdata);
        end
        if (ctl.mul_k) begin
            prod_reg <= PW'(p1_reg) * PW'(dim_rdata);
        end
        if (ctl.sum) begin
            q_reg <= (sum > SW'(mcod_pkg::COST_MAX)) ? mcod_pkg::COST_MAX
                                                     : sum[mcod_pkg::COST_W-1:0];
        end
        if (ctl.clr) begin
            have_reg <= 1'b0;
        end else if (ctl.cmp && (!have_reg || (q_reg < best_reg))) begin
            best_reg   <= q_reg;
            best_k_reg <= split_cand;
            have_reg   <= 1'b1;
        end
    end

    assign best_cost  = best_reg;
    assign best_split = best_k_reg;

endmodule

FILE: rtl/matrix_chain_order_dp_core.sv
// ----------------------------------------------------------------------------
// matrix_chain_order_dp_core
// Matrix chain multiplication order: dimension loading, bottom-up cost and
// split table fill, and sub-chain queries.
// ----------------------------------------------------------------------------
// A load beat without tlast leaves the block ready, so loads follow back to
// back. The closing load runs the table fill on one shared multiply, add and
// compare unit: the diagonal is written with zero cost, then each cell reads
// its outer dimensions in S_CELL and S_RDB and multiplies them in S_MULAB,
// each split candidate passes through S_RDK, S_MULK, S_SUM and S_CMP, and
// the cell is written in S_WR. A query reads the table memory in S_QRD and
// captures the result in S_QCAP. The block is not ready while an item is at
// work; a result beat waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp_core #(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_BITS     = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // dim_value[11:0], first_matrix[15:12], last_matrix[19:16], zero pad
    input  logic [mcod_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // min_cost[39:0], split_after[43:40], zero pad
    output logic [mcod_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [mcod_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int NDIMS = MAX_MATRICES + 1;
    localparam int IW    = $clog2(MAX_MATRICES);
    localparam int DAW   = $clog2(NDIMS);
    localparam int CW    = $clog2(NDIMS + 1);
    localparam int CAW   = 2 * IW;
    localparam int PADW  = mcod_pkg::M_TDATA_W - mcod_pkg::COST_W - mcod_pkg::SPLIT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_QCAP,
        S_DIAG,
        S_CELL,
        S_RDB,
        S_MULAB,
        S_RDK,
        S_MULK,
        S_SUM,
        S_CMP,
        S_WR,
        S_EMIT
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        ovf_reg;
    logic                        chain_ready_reg;
    logic [CW-1:0]               n_reg;
    logic [CW-1:0]               len_reg;
    logic [IW-1:0]               a_reg;
    logic [IW-1:0]               b_reg;
    logic [IW-1:0]               k_reg;
    logic [IW-1:0]               qf_reg;
    logic [IW-1:0]               ql_reg;
    logic [mcod_pkg::COST_W-1:0] res_cost_reg;
    logic [IW-1:0]               res_split_reg;
    mcod_pkg::status_t           res_status_reg;
    logic                        m_valid_reg;
    logic [mcod_pkg::COST_W-1:0] m_cost_reg;
    logic [mcod_pkg::SPLIT_W-1:0] m_split_reg;
    mcod_pkg::status_t           m_status_reg;

    logic                        accept;
    logic                        is_query;
    logic [DIM_BITS-1:0]         in_dim;
    logic [mcod_pkg::IDX_W-1:0]  in_fm;
    logic [mcod_pkg::IDX_W-1:0]  in_lm;
    logic [CW-1:0]               cnt_eff;
    logic                        ovf_eff;
    logic                        room;
    logic [CW-1:0]               cnt_new;
    logic                        ovf_new;
    logic                        q_bad;
    logic                        more_cells;
    logic                        more_lens;

    logic                        dim_we;
    logic                        dim_re;
    logic [DAW-1:0]              dim_raddr;
    logic [DIM_BITS-1:0]         dim_rdata;
    logic                        tab_we;
    logic [CAW-1:0]              tab_waddr;
    logic [mcod_pkg::COST_W-1:0] cost_wdata;
    logic [IW-1:0]               split_wdata;
    logic                        cost_re;
    logic [CAW-1:0]              cost_raddr_a;
    logic [CAW-1:0]              cost_raddr_b;
    logic [mcod_pkg::COST_W-1:0] cost_rdata_a;
    logic [mcod_pkg::COST_W-1:0] cost_rdata_b;
    logic                        split_re;
    logic [IW-1:0]               split_rdata;
    mcod_pkg::alu_ctl_t          alu_ctl;
    logic [IW-1:0]               split_cand;
    logic [mcod_pkg::COST_W-1:0] best_cost;
    logic [IW-1:0]               best_split;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_query = (s_tuser == mcod_pkg::KIND_QUERY);
    assign in_dim   = DIM_BITS'(s_tdata[11:0]);
    assign in_fm    = s_tdata[15:12];
    assign in_lm    = s_tdata[19:16];

    assign cnt_eff = chain_ready_reg ? '0 : cnt_reg;
    assign ovf_eff = chain_ready_reg ? 1'b0 : ovf_reg;
    assign room    = (cnt_eff < CW'(NDIMS));
    assign cnt_new = room ? (cnt_eff + CW'(1)) : cnt_eff;
    assign ovf_new = ovf_eff || !room;
    assign q_bad   = (in_fm > in_lm) || ((int'(in_lm) + 1) >= int'(cnt_reg))
                  || (int'(in_lm) >= MAX_MATRICES);

    assign more_cells = ((CW+1)'(a_reg) + (CW+1)'(len_reg) + (CW+1)'(1)) <= (CW+1)'(n_reg);
    assign more_lens  = ((CW+1)'(len_reg) + (CW+1)'(1)) <= (CW+1)'(n_reg);
    assign split_cand = k_reg - a_reg + IW'(1);

    assign dim_we = accept && !is_query && room;

    always_comb begin
        dim_re       = 1'b0;
        dim_raddr    = '0;
        tab_we       = 1'b0;
        tab_waddr    = {a_reg, b_reg};
        cost_wdata   = best_cost;
        split_wdata  = best_split;
        cost_re      = 1'b0;
        cost_raddr_a = {a_reg, k_reg};
        cost_raddr_b = {k_reg + IW'(1), b_reg};
        split_re     = 1'b0;
        alu_ctl      = '0;
        unique case (state_reg)
            S_QRD: begin
                cost_re      = 1'b1;
                split_re     = 1'b1;
                cost_raddr_a = {qf_reg, ql_reg};
            end
            S_DIAG: begin
                tab_we      = 1'b1;
                tab_waddr   = {a_reg, a_reg};
                cost_wdata  = '0;
                split_wdata = '0;
            end
            S_CELL: begin
                dim_re      = 1'b1;
                dim_raddr   = DAW'(a_reg);
                alu_ctl.clr = 1'b1;
            end
            S_RDB: begin
                dim_re        = 1'b1;
                dim_raddr     = DAW'(CW'(b_reg) + CW'(1));
                alu_ctl.cap_a = 1'b1;
            end
            S_MULAB: begin
                alu_ctl.mul_ab = 1'b1;
            end
            S_RDK: begin
                dim_re    = 1'b1;
                dim_raddr = DAW'(CW'(k_reg) + CW'(1));
                cost_re   = 1'b1;
            end
            S_MULK: begin
                alu_ctl.mul_k = 1'b1;
            end
            S_SUM: begin
                alu_ctl.sum = 1'b1;
            end
            S_CMP: begin
                alu_ctl.cmp = 1'b1;
            end
            S_WR: begin
                tab_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            ovf_reg         <= 1'b0;
            chain_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept && !is_query) begin
                        chain_ready_reg <= 1'b0;
                        res_cost_reg    <= '0;
                        res_split_reg   <= '0;
                        if (!s_tlast) begin
                            cnt_reg <= cnt_new;
                            ovf_reg <= ovf_new;
                        end else if (ovf_new) begin
                            cnt_reg        <= '0;
                            ovf_reg        <= 1'b0;
                            res_status_reg <= mcod_pkg::ST_TOO_MANY;
                            state_reg      <= S_EMIT;
                        end else if (cnt_new < CW'(2)) begin
                            cnt_reg        <= '0;
                            ovf_reg        <= 1'b0;
                            res_status_reg <= mcod_pkg::ST_NO_CHAIN;
                            state_reg      <= S_EMIT;
                        end else begin
                            cnt_reg   <= cnt_new;
                            ovf_reg   <= 1'b0;
                            n_reg     <= cnt_new - CW'(1);
                            a_reg     <= '0;
                            state_reg <= S_DIAG;
                        end
                    end else if (accept) begin
                        res_cost_reg  <= '0;
                        res_split_reg <= '0;
                        qf_reg        <= IW'(in_fm);
                        ql_reg        <= IW'(in_lm);
                        if (!chain_ready_reg) begin
                            res_status_reg <= mcod_pkg::ST_NO_CHAIN;
                            state_reg      <= S_EMIT;
                        end else if (q_bad) begin
                            res_status_reg <= mcod_pkg::ST_BAD_INDEX;
                            state_reg      <= S_EMIT;
                        end else begin
                            state_reg <= S_QRD;
                        end
                    end
                end
                S_QRD: begin
                    state_reg <= S_QCAP;
                end
                S_QCAP: begin
                    res_cost_reg   <= cost_rdata_a;
                    res_split_reg  <= split_rdata;
                    res_status_reg <= mcod_pkg::ST_OK;
                    state_reg      <= S_EMIT;
                end
                S_DIAG: begin
                    if ((CW'(a_reg) + CW'(1)) == n_reg) begin
                        a_reg   <= '0;
                        len_reg <= CW'(2);
                        if (n_reg < CW'(2)) begin
                            chain_ready_reg <= 1'b1;
                            res_status_reg  <= mcod_pkg::ST_OK;
                            state_reg       <= S_EMIT;
                        end else begin
                            state_reg <= S_CELL;
                        end
                    end else begin
                        a_reg <= a_reg + IW'(1);
                    end
                end
                S_CELL: begin
                    b_reg     <= IW'(CW'(a_reg) + len_reg - CW'(1));
                    k_reg     <= a_reg;
                    state_reg <= S_RDB;
                end
                S_RDB: begin
                    state_reg <= S_MULAB;
                end
                S_MULAB: begin
                    state_reg <= S_RDK;
                end
                S_RDK: begin
                    state_reg <= S_MULK;
                end
                S_MULK: begin
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (k_reg == (b_reg - IW'(1))) begin
                        state_reg <= S_WR;
                    end else begin
                        k_reg     <= k_reg + IW'(1);
                        state_reg <= S_RDK;
                    end
                end
                S_WR: begin
                    if (more_cells) begin
                        a_reg     <= a_reg + IW'(1);
                        state_reg <= S_CELL;
                    end else if (more_lens) begin
                        a_reg     <= '0;
                        len_reg   <= len_reg + CW'(1);
                        state_reg <= S_CELL;
                    end else begin
                        chain_ready_reg <= 1'b1;
                        res_cost_reg    <= best_cost;
                        res_split_reg   <= best_split;
                        res_status_reg  <= mcod_pkg::ST_OK;
                        state_reg       <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_cost_reg   <= res_cost_reg;
                        m_split_reg  <= mcod_pkg::SPLIT_W'(res_split_reg);
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    mcod_ram_1r #(
        .WIDTH (DIM_BITS),
        .DEPTH (NDIMS),
        .AW    (DAW)
    ) u_dim_ram (
        .aclk  (aclk),
        .we    (dim_we),
        .waddr (DAW'(cnt_eff)),
        .wdata (in_dim),
        .re    (dim_re),
        .raddr (dim_raddr),
        .rdata (dim_rdata)
    );

    mcod_ram_2r #(
        .WIDTH (mcod_pkg::COST_W),
        .AW    (CAW)
    ) u_cost_ram (
        .aclk    (aclk),
        .we      (tab_we),
        .waddr   (tab_waddr),
        .wdata   (cost_wdata),
        .re      (cost_re),
        .raddr_a (cost_raddr_a),
        .raddr_b (cost_raddr_b),
        .rdata_a (cost_rdata_a),
        .rdata_b (cost_rdata_b)
    );

    mcod_ram_1r #(
        .WIDTH (IW),
        .DEPTH (1 << CAW),
        .AW    (CAW)
    ) u_split_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (split_wdata),
        .re    (split_re),
        .raddr ({qf_reg, ql_reg}),
        .rdata (split_rdata)
    );

    mcod_alu #(
        .DIM_BITS (DIM_BITS),
        .IW       (IW)
    ) u_alu (
        .aclk       (aclk),
        .ctl        (alu_ctl),
        .dim_rdata  (dim_rdata),
        .cost_l     (cost_rdata_a),
        .cost_r     (cost_rdata_b),
        .split_cand (split_cand),
        .best_cost  (best_cost),
        .best_split (best_split)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, m_split_reg, m_cost_reg};
    assign m_tuser  = m_status_reg;

endmodule

FILE: rtl/mcod_checker.sv
// ----------------------------------------------------------------------------
// mcod_checker
// Port-level checks of the matrix chain order core, bound to the top level.
// ----------------------------------------------------------------------------
module mcod_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mcod_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mcod_pkg::STATUS_W-1:0]  m_tuser
);

    a_no_beat_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result beat right after reset");

    a_busy_after_query: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mcod_pkg::KIND_QUERY) |=> !s_tready
    ) else $error("ready right after a query beat");

    a_busy_after_close: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mcod_pkg::KIND_LOAD) && s_tlast |=> !s_tready
    ) else $error("ready right after a closing load beat");

    a_error_zero_data: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != mcod_pkg::ST_OK) |-> (m_tdata == '0)
    ) else $error("error beat with nonzero data");

    a_stall_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    ) else $error("stalled result beat changed");

endmodule

bind matrix_chain_order_dp_core mcod_checker u_mcod_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
